@@ hw/rtl/rbri_pkg.sv @@
package rbri_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_DERIV,
        OP_ADV,
        OP_FINAL,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_SET,
        SUM_ADD1,
        SUM_ADD2
    } sum_t;

    // one entry of the integration program
    typedef struct packed {
        op_t  op;
        logic src_tmp;   // derivative taken at the trial vector
        logic dst_tmp;   // advance writes the trial vector
        logic base_tmp;  // advance starts from the trial vector
        logic half;      // half step
        sum_t sum;       // weighted sum of slopes
    } step_t;

    localparam logic [1:0] METH_EULER  = 2'd0;
    localparam logic [1:0] METH_RK4    = 2'd1;
    localparam logic [1:0] METH_MID    = 2'd2;
    localparam logic [1:0] METH_VERLET = 2'd3;

    localparam logic [2:0] CFG_COEF_X = 3'd0;
    localparam logic [2:0] CFG_COEF_Y = 3'd1;
    localparam logic [2:0] CFG_COEF_Z = 3'd2;
    localparam logic [2:0] CFG_DT     = 3'd3;
    localparam logic [2:0] CFG_METHOD = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    function automatic step_t prog_lookup(input logic [1:0] method, input logic [3:0] phase);
        step_t s;
        s = '0;
        s.op = OP_END;
        if (phase == 4'd0) begin
            s.op  = OP_DERIV;
            s.sum = (method == METH_RK4) ? SUM_SET : SUM_NONE;
        end else begin
            case (method)
                METH_EULER: begin
                    if (phase == 4'd1) s.op = OP_ADV;
                end
                METH_RK4: begin
                    case (phase)
                        4'd1, 4'd3: begin
                            s.op = OP_ADV; s.half = 1'b1; s.dst_tmp = 1'b1;
                        end
                        4'd2, 4'd4: begin
                            s.op = OP_DERIV; s.src_tmp = 1'b1; s.sum = SUM_ADD2;
                        end
                        4'd5: begin
                            s.op = OP_ADV; s.dst_tmp = 1'b1;
                        end
                        4'd6: begin
                            s.op = OP_DERIV; s.src_tmp = 1'b1; s.sum = SUM_ADD1;
                        end
                        4'd7: s.op = OP_FINAL;
                        default: s.op = OP_END;
                    endcase
                end
                default: begin
                    case (phase)
                        4'd1: begin
                            s.op = OP_ADV; s.half = 1'b1; s.dst_tmp = 1'b1;
                        end
                        4'd2: begin
                            s.op = OP_DERIV; s.src_tmp = 1'b1;
                        end
                        4'd3: begin
                            s.op       = OP_ADV;
                            s.half     = (method == METH_VERLET);
                            s.base_tmp = (method == METH_VERLET);
                        end
                        default: s.op = OP_END;
                    endcase
                end
            endcase
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/rbri_mul.sv @@
module rbri_mul import rbri_pkg::*; #(
    parameter int AW = 65,
    parameter int BW = 37
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic signed [AW-1:0]    a_in,
    input  logic [BW-1:0]           b_in,
    output logic signed [AW+BW-1:0] prod,
    output logic                    done
);

    localparam int BD  = (BW + 7) / 8;
    localparam int BWR = BD * 8;
    localparam int UW  = AW + 9;
    localparam int CW  = (BD > 1) ? $clog2(BD) : 1;

    logic signed [AW-1:0]     a_reg;
    logic [BWR-1:0]           b_reg;
    logic signed [UW+BWR-1:0] acc_reg, acc_next;
    logic [CW-1:0]            cnt_reg;
    logic                     busy_reg, done_reg;
    logic signed [UW-1:0]     part, upper_sum;

    // radix-256 shift-add: add one digit product on top, then shift right one digit
    always_comb begin
        part      = a_reg * $signed({1'b0, b_reg[7:0]});
        upper_sum = $signed(acc_reg[UW+BWR-1:BWR]) + part;
        acc_next  = $signed({upper_sum, acc_reg[BWR-1:0]}) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BD - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg   <= a_in;
            b_reg   <= BWR'(b_in);
            acc_reg <= '0;
        end else if (busy_reg) begin
            b_reg   <= b_reg >> 8;
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg[AW+BW-1:0];
    assign done = done_reg;

endmodule

@@ hw/rtl/rigid_body_rate_integrator.sv @@
// Load beat: from idle straight to the done state, which registers the result. Step beat:
// each multiply runs on the shared radix-256 unit over BD digits, BD = ceil(max(32,
// RATE_WIDTH+5)/8); a slope vector is 6 multiplies, an advance 3, the RK4 combine 6. One
// beat in flight; the next is taken while a result waits on m_tready. Reset (aresetn,
// synchronous): rates, coefficients, step zero, RK4.
module rigid_body_rate_integrator import rbri_pkg::*; #(
    parameter int RATE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // omega_x_in, omega_y_in, omega_z_in
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // omega_x_out, omega_y_out, omega_z_out
    output logic        m_tuser,   // saturated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int W  = RATE_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int BW = (W + 5 > 32) ? W + 5 : 32;
    localparam int PW = AW + BW;
    localparam int SW = W + 3;
    localparam int K  = W + 7;
    localparam int XW = (W > 32) ? W : 32;

    localparam logic [BW-1:0] RECIP = BW'(((64'd1 << K) + 64'd5) / 64'd6);
    localparam logic signed [PW-1:0] RMAX   = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] RMIN   = ~RMAX;
    localparam logic signed [PW-1:0] OFFSET = PW'(3) << (W + 2);
    localparam logic signed [PW-1:0] QBIAS  = PW'(1) << (W + 1);

    state_t state_reg, state_next;
    logic [3:0] phase_reg, phase_next;
    logic [1:0] comp_reg, comp_next;
    logic       mstep_reg, mstep_next;
    logic       flag_reg, flag_next;

    logic signed [W-1:0]  rate_reg [3];
    logic signed [W-1:0]  rate_next [3];
    logic signed [W-1:0]  tmp_reg [3];
    logic signed [W-1:0]  tmp_next [3];
    logic signed [W-1:0]  k_reg [3];
    logic signed [W-1:0]  k_next [3];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic signed [30:0]   coef_reg [3];
    logic signed [30:0]   coef_next [3];
    logic [31:0]          dt_reg, dt_next;
    logic [1:0]           method_reg, method_next;

    logic        m_valid_reg, m_valid_next;
    logic [95:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;

    logic                   mul_load, mul_done;
    logic signed [AW-1:0]   mul_a;
    logic [BW-1:0]          mul_b;
    logic signed [PW-1:0]   mul_prod;

    step_t                cur;
    logic signed [W-1:0]  src_j, src_k, base0, kv;
    logic [W-1:0]         mag_k;
    logic [30:0]          mag_c;
    logic signed [AW-1:0] a_first, a_second;
    logic signed [PW-1:0] inc, tprime, qv;
    logic [W:0]           kv_s, adv_s, fin_s;
    logic [W:0]           ld_s [3];
    logic                 next_comp;

    function automatic logic [W:0] sat_pw(input logic signed [PW-1:0] x);
        if (x > RMAX)
            return {1'b1, RMAX[W-1:0]};
        else if (x < RMIN)
            return {1'b1, RMIN[W-1:0]};
        else
            return {1'b0, x[W-1:0]};
    endfunction

    function automatic logic [31:0] out32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        e = XW'(v);
        return e[31:0];
    endfunction

    rbri_mul #(.AW(AW), .BW(BW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (mul_load),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    assign cur = prog_lookup(method_reg, phase_reg);

    // component under work always sits at position 0; vectors rotate after each one
    always_comb begin
        src_j    = cur.src_tmp ? tmp_reg[1] : rate_reg[1];
        src_k    = cur.src_tmp ? tmp_reg[2] : rate_reg[2];
        base0    = cur.base_tmp ? tmp_reg[0] : rate_reg[0];
        mag_k    = src_k[W-1] ? W'(-src_k) : W'(src_k);
        mag_c    = coef_reg[0][30] ? 31'(-coef_reg[0]) : 31'(coef_reg[0]);
        a_first  = src_k[W-1] ? -AW'(src_j) : AW'(src_j);
        a_second = coef_reg[0][30] ? -AW'($signed(mul_prod[2*W-1:0]))
                                   : AW'($signed(mul_prod[2*W-1:0]));
        kv_s     = sat_pw(mul_prod >>> 54);
        kv       = kv_s[W-1:0];
        inc      = cur.half ? (mul_prod >>> 33) : (mul_prod >>> 32);
        adv_s    = sat_pw(PW'(base0) + inc);
        tprime   = (mul_prod >>> 32) + OFFSET;
        qv       = (mul_prod >>> K) - QBIAS;
        fin_s    = sat_pw(PW'(rate_reg[0]) + qv);
        ld_s[0]  = sat_pw(PW'($signed(s_tdata[31:0])));
        ld_s[1]  = sat_pw(PW'($signed(s_tdata[63:32])));
        ld_s[2]  = sat_pw(PW'($signed(s_tdata[95:64])));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = (s_tuser == KIND_STEP) ? ST_LOAD : ST_DONE;
            end
            ST_LOAD: state_next = (cur.op == OP_END) ? ST_DONE : ST_MUL;
            ST_MUL:  if (mul_done) state_next = ST_POST;
            ST_POST: state_next = ST_LOAD;
            ST_DONE: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        logic signed [W-1:0]  r0, t0, k0;
        logic signed [SW-1:0] s0;
        logic signed [30:0]   c0;
        phase_next  = phase_reg;
        comp_next   = comp_reg;
        mstep_next  = mstep_reg;
        flag_next   = flag_reg;
        rate_next   = rate_reg;
        tmp_next    = tmp_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        coef_next   = coef_reg;
        dt_next     = dt_reg;
        method_next = method_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        mul_load    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        next_comp   = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_COEF_X: coef_next[0] = $signed(cfg_wdata[30:0]);
                CFG_COEF_Y: coef_next[1] = $signed(cfg_wdata[30:0]);
                CFG_COEF_Z: coef_next[2] = $signed(cfg_wdata[30:0]);
                CFG_DT:     dt_next = cfg_wdata;
                CFG_METHOD: method_next = cfg_wdata[1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    phase_next = '0;
                    comp_next  = '0;
                    mstep_next = 1'b0;
                    flag_next  = 1'b0;
                    if (s_tuser == KIND_LOAD) begin
                        rate_next[0] = ld_s[0][W-1:0];
                        rate_next[1] = ld_s[1][W-1:0];
                        rate_next[2] = ld_s[2][W-1:0];
                        flag_next    = ld_s[0][W] | ld_s[1][W] | ld_s[2][W];
                    end
                end
            end
            ST_LOAD: begin
                if (cur.op != OP_END) begin
                    mul_load = 1'b1;
                    case (cur.op)
                        OP_DERIV: begin
                            mul_a = mstep_reg ? a_second : a_first;
                            mul_b = mstep_reg ? BW'(mag_c) : BW'(mag_k);
                        end
                        OP_ADV: begin
                            mul_a = AW'(k_reg[0]);
                            mul_b = BW'(dt_reg);
                        end
                        default: begin
                            mul_a = mstep_reg ? tprime[AW-1:0] : AW'(sum_reg[0]);
                            mul_b = mstep_reg ? RECIP : BW'(dt_reg);
                        end
                    endcase
                end
            end
            ST_POST: begin
                case (cur.op)
                    OP_DERIV: begin
                        if (!mstep_reg) begin
                            mstep_next = 1'b1;
                        end else begin
                            k_next[0] = kv;
                            flag_next = flag_reg | kv_s[W];
                            case (cur.sum)
                                SUM_SET:  sum_next[0] = SW'(kv);
                                SUM_ADD1: sum_next[0] = sum_reg[0] + SW'(kv);
                                SUM_ADD2: sum_next[0] = sum_reg[0] + (SW'(kv) <<< 1);
                                default: ;
                            endcase
                            next_comp = 1'b1;
                        end
                    end
                    OP_ADV: begin
                        if (cur.dst_tmp) tmp_next[0] = adv_s[W-1:0];
                        else rate_next[0] = adv_s[W-1:0];
                        flag_next = flag_reg | adv_s[W];
                        next_comp = 1'b1;
                    end
                    OP_FINAL: begin
                        if (!mstep_reg) begin
                            mstep_next = 1'b1;
                        end else begin
                            rate_next[0] = fin_s[W-1:0];
                            flag_next    = flag_reg | fin_s[W];
                            next_comp    = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (next_comp) begin
                    mstep_next = 1'b0;
                    if (comp_reg == 2'd2) begin
                        comp_next  = '0;
                        phase_next = phase_reg + 1'b1;
                    end else begin
                        comp_next = comp_reg + 1'b1;
                    end
                    r0 = rate_next[0]; rate_next[0] = rate_next[1];
                    rate_next[1] = rate_next[2]; rate_next[2] = r0;
                    t0 = tmp_next[0]; tmp_next[0] = tmp_next[1];
                    tmp_next[1] = tmp_next[2]; tmp_next[2] = t0;
                    k0 = k_next[0]; k_next[0] = k_next[1];
                    k_next[1] = k_next[2]; k_next[2] = k0;
                    s0 = sum_next[0]; sum_next[0] = sum_next[1];
                    sum_next[1] = sum_next[2]; sum_next[2] = s0;
                    c0 = coef_next[0]; coef_next[0] = coef_next[1];
                    coef_next[1] = coef_next[2]; coef_next[2] = c0;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {out32(rate_reg[2]), out32(rate_reg[1]), out32(rate_reg[0])};
                    m_user_next  = flag_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            comp_reg    <= '0;
            mstep_reg   <= 1'b0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            dt_reg      <= '0;
            method_reg  <= METH_RK4;
            for (int i = 0; i < 3; i++) begin
                rate_reg[i] <= '0;
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            comp_reg    <= comp_next;
            mstep_reg   <= mstep_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
            dt_reg      <= dt_next;
            method_reg  <= method_next;
            rate_reg    <= rate_next;
            coef_reg    <= coef_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg    <= tmp_next;
        k_reg      <= k_next;
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside the multiply state");

    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        comp_reg != 2'd3)
        else $error("component counter out of range");

    a_idle_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (comp_reg == 2'd0 && !mstep_reg))
        else $error("vectors not aligned when idle");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOAD || state_reg == ST_DONE))
        else $error("accepted beat not dispatched");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");

endmodule
